// ----- hdl/ppao_pkg.sv -----
// Shared constants, types and the sine table builder for the phase accumulator oscillator.
package ppao_pkg;

    localparam int MAX_VOICES   = 128;
    localparam int SINE_ENTRIES = 1028;

    localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VOICES + 1);
    localparam int SIDX_W = $clog2(SINE_ENTRIES);
    localparam int VAL_W  = 9;
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int SC_W   = SUM_W + 5;
    localparam int DCNT_W = $clog2(SC_W + 1);

    localparam logic [1:0] SHAPE_SAW    = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE = 2'd1;
    localparam logic [1:0] SHAPE_TRI    = 2'd2;
    localparam logic [1:0] SHAPE_SINE   = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic CFG_WAVE_SHAPE = 1'b0;
    localparam logic CFG_VOLUME     = 1'b1;

    localparam logic [3:0] VOLUME_RESET = 4'd6;
    localparam logic [3:0] VOLUME_FULL  = 4'd8;

    localparam logic [31:0] PHASE_HALF = 32'h7FFF_FFFF;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'h4000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_SCALE,
        S_DIVGO,
        S_DIV,
        S_OUT
    } state_t;

    typedef logic signed [7:0] sine_rom_t [SINE_ENTRIES];

    // restoring long division, used only for the table math at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin of a quarter-turn fraction in Q30, Taylor series to eight terms
    function automatic logic [63:0] quarter_sine(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] den;
        if (u >= ONE_Q30) begin
            return ONE_Q30;
        end
        x    = (u * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        s    = x;
        for (int k = 1; k <= 7; k++) begin
            den  = 64'((2 * k) * (2 * k + 1));
            term = udiv64((term * x2) >> 30, den);
            if (k % 2 == 1) begin
                s = s - term;
            end else begin
                s = s + term;
            end
        end
        return s;
    endfunction

    // elaboration-time build of the truncated 127*sin table
    function automatic sine_rom_t build_sine();
        sine_rom_t   rom;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] m;
        logic [1:0]  q;
        logic [7:0]  mag;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            t   = udiv64(64'(i) << 32, 64'(SINE_ENTRIES));
            q   = t[31:30];
            u   = t & (ONE_Q30 - 64'd1);
            if (q[0]) begin
                u = ONE_Q30 - u;
            end
            m   = (64'd127 * quarter_sine(u)) >> 30;
            mag = m[7:0];
            rom[i] = q[1] ? -$signed(mag) : $signed(mag);
        end
        return rom;
    endfunction

endpackage

// ----- hdl/polyphonic_phase_accumulator_oscillator.sv -----
// Top level: polyphonic phase accumulator oscillator and mixer.
// A load word (req_type 0) writes step_size into voice_slot's step memory and returns
// nothing; slots at or above MAX_VOICES (128) are ignored. A tick word (req_type 1)
// walks voices 0..N-1 (N = active_voices, capped at 128) through a five-stage voice
// pipeline: memory read, phase add and write-back, waveform and sine index multiply,
// sine table read, accumulate. One voice enters per cycle, and the walk holds the
// sequencer until the pipeline is empty. The sum is then scaled by volume in a
// registered step and divided by N in a one-bit-per-cycle divider (a start state, the
// quotient bits, then a hand-off; skipped when N is zero), and the offset is added and
// the result clamped to 0..255. The sample is registered once the output register is
// free; in_stall is high from the accepted tick until then, and a load leaves it low.
// The result sits in an output register, so the next word is taken while it waits.
// Phase accumulators clear at reset through per-voice valid flags; no clearing pass.
module polyphonic_phase_accumulator_oscillator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [6:0]  voice_slot,
    input  logic [31:0] step_size,
    input  logic [7:0]  active_voices,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_sample,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int MAXV   = ppao_pkg::MAX_VOICES;
    localparam int VIDX_W = ppao_pkg::VIDX_W;
    localparam int CNT_W  = ppao_pkg::CNT_W;
    localparam int SIDX_W = ppao_pkg::SIDX_W;
    localparam int VAL_W  = ppao_pkg::VAL_W;
    localparam int SUM_W  = ppao_pkg::SUM_W;
    localparam int SC_W   = ppao_pkg::SC_W;

    // configuration
    logic [1:0] shape_reg;
    logic [3:0] volume_reg;
    logic [3:0] vol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            shape_reg  <= ppao_pkg::SHAPE_SAW;
            volume_reg <= ppao_pkg::VOLUME_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ppao_pkg::CFG_WAVE_SHAPE: shape_reg  <= cfg_data[1:0];
                ppao_pkg::CFG_VOLUME:     volume_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign vol = (volume_reg > ppao_pkg::VOLUME_FULL) ? ppao_pkg::VOLUME_FULL : volume_reg;

    // sequencer
    ppao_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             issue;
    logic             pipe_busy;
    logic             div_busy;
    logic             out_load;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    assign in_stall = (state_reg != ppao_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign issue    = (state_reg == ppao_pkg::S_RUN) && (rd_cnt_reg < n_reg);
    assign out_load = (state_reg == ppao_pkg::S_OUT) && (!out_valid || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppao_pkg::S_IDLE:
                if (accept && req_type == ppao_pkg::REQ_TICK) begin
                    state_next = ppao_pkg::S_RUN;
                end
            ppao_pkg::S_RUN:
                if (!issue && !pipe_busy) begin
                    state_next = ppao_pkg::S_SCALE;
                end
            ppao_pkg::S_SCALE:
                state_next = (n_reg == '0) ? ppao_pkg::S_OUT : ppao_pkg::S_DIVGO;
            ppao_pkg::S_DIVGO:
                state_next = ppao_pkg::S_DIV;
            ppao_pkg::S_DIV:
                if (!div_busy) begin
                    state_next = ppao_pkg::S_OUT;
                end
            ppao_pkg::S_OUT:
                if (out_load) begin
                    state_next = ppao_pkg::S_IDLE;
                end
            default:
                state_next = ppao_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ppao_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            n_reg      <= '0;
            rd_cnt_reg <= '0;
        end else if (accept && req_type == ppao_pkg::REQ_TICK) begin
            n_reg      <= (active_voices > 8'(MAXV)) ? CNT_W'(MAXV) : CNT_W'(active_voices);
            rd_cnt_reg <= '0;
        end else if (issue) begin
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
    end

    // voice memories: steps undefined until loaded, phases cleared via valid flags
    logic [31:0]       step_mem  [MAXV];
    logic [31:0]       phase_mem [MAXV];
    logic [MAXV-1:0]   ph_vld_reg;
    logic [31:0]       step_rd_reg;
    logic [31:0]       phase_rd_reg;
    logic              load_ok;

    // stage valids and payload
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [VIDX_W-1:0] idx1_reg;
    logic [31:0]       p_new;
    logic [31:0]       p2_reg;
    logic signed [VAL_W-1:0] val_next;
    logic signed [VAL_W-1:0] val3_reg, val4_reg;
    logic [31+SIDX_W:0] sprod;
    logic [SIDX_W-1:0] sidx3_reg;
    logic signed [7:0] sine_q;
    logic signed [SUM_W-1:0] acc_reg;

    assign load_ok   = accept && (req_type == ppao_pkg::REQ_LOAD) && (32'(voice_slot) < MAXV);
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign p_new     = (ph_vld_reg[idx1_reg] ? phase_rd_reg : 32'd0) + step_rd_reg;

    always_ff @(posedge clk)
    begin
        if (load_ok) begin
            step_mem[VIDX_W'(voice_slot)] <= step_size;
        end
        if (issue) begin
            step_rd_reg  <= step_mem[rd_cnt_reg[VIDX_W-1:0]];
            phase_rd_reg <= phase_mem[rd_cnt_reg[VIDX_W-1:0]];
        end
        if (v1_reg) begin
            phase_mem[idx1_reg] <= p_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ph_vld_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end else begin
            if (v1_reg) begin
                ph_vld_reg[idx1_reg] <= 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // per-voice waveform value; sine index is phase * (entries-1) / 2^32
    always_comb
    begin
        case (shape_reg)
            ppao_pkg::SHAPE_SAW:
                val_next = $signed({1'b0, p2_reg[31:24]}) - VAL_W'(128);
            ppao_pkg::SHAPE_SQUARE:
                val_next = (p2_reg < ppao_pkg::PHASE_HALF) ? VAL_W'(63) : -VAL_W'(64);
            ppao_pkg::SHAPE_TRI:
                val_next = (p2_reg < ppao_pkg::PHASE_HALF) ?
                           $signed({1'b0, p2_reg[31:24]}) :
                           $signed({1'b0, 8'((32'd0 - p2_reg) >> 24)});
            default:
                val_next = '0;
        endcase
    end

    assign sprod = p2_reg * (SIDX_W)'(ppao_pkg::SINE_ENTRIES - 1);

    always_ff @(posedge clk)
    begin
        idx1_reg  <= rd_cnt_reg[VIDX_W-1:0];
        p2_reg    <= p_new;
        val3_reg  <= val_next;
        sidx3_reg <= sprod[31+SIDX_W:32];
        val4_reg  <= val3_reg;
    end

    ppao_sine_rom u_sine (
        .clk  (clk),
        .addr (sidx3_reg),
        .data (sine_q)
    );

    always_ff @(posedge clk)
    begin
        if (accept) begin
            acc_reg <= '0;
        end else if (v4_reg) begin
            acc_reg <= acc_reg + ((shape_reg == ppao_pkg::SHAPE_SINE) ?
                                  SUM_W'(sine_q) : SUM_W'(val4_reg));
        end
    end

    // volume scaling: floor shift for saw, truncating *vol/8 otherwise
    logic signed [SC_W-1:0] prod;
    logic signed [SC_W-1:0] scaled_next;
    logic signed [SC_W-1:0] scaled_reg;
    logic signed [SC_W-1:0] quo;
    logic signed [SC_W:0]   res;

    assign prod = SC_W'(acc_reg) * $signed({1'b0, vol});

    always_comb
    begin
        if (shape_reg == ppao_pkg::SHAPE_SAW) begin
            scaled_next = SC_W'(acc_reg) >>> (4'd8 - vol);
        end else if (prod < 0) begin
            scaled_next = (prod + SC_W'(7)) >>> 3;
        end else begin
            scaled_next = prod >>> 3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ppao_pkg::S_SCALE) begin
            scaled_reg <= scaled_next;
        end
    end

    ppao_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ppao_pkg::S_DIVGO),
        .dividend (scaled_reg),
        .divisor  (n_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    // offset and clamp
    assign res = ((shape_reg == ppao_pkg::SHAPE_SQUARE) ? (SC_W+1)'(64) : (SC_W+1)'(128))
               + ((n_reg == '0) ? (SC_W+1)'(0) : (SC_W+1)'(quo));

    logic       out_valid_reg;
    logic [7:0] out_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            if (res < 0) begin
                out_sample_reg <= 8'd0;
            end else if (res > (SC_W+1)'(255)) begin
                out_sample_reg <= 8'd255;
            end else begin
                out_sample_reg <= res[7:0];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    // checks
    a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == ppao_pkg::S_DIV)
        else $error("divider busy outside divide state");

    a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_busy |-> state_reg == ppao_pkg::S_RUN)
        else $error("voice pipeline active outside voice walk");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppao_pkg::S_OUT && out_valid && out_stall) |=>
        state_reg == ppao_pkg::S_OUT)
        else $error("result left before output register freed");

endmodule

// ----- hdl/ppao_sine_rom.sv -----
// Read-only sine table with a registered read port.
module ppao_sine_rom (
    input  logic                           clk,
    input  logic [ppao_pkg::SIDX_W-1:0]    addr,
    output logic signed [7:0]              data
);

    localparam ppao_pkg::sine_rom_t ROM = ppao_pkg::build_sine();

    logic signed [7:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

// ----- hdl/ppao_div.sv -----
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module ppao_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ppao_pkg::SC_W-1:0]   dividend,
    input  logic [ppao_pkg::CNT_W-1:0]         divisor,
    output logic                               busy,
    output logic signed [ppao_pkg::SC_W-1:0]   quotient
);

    localparam int SC_W   = ppao_pkg::SC_W;
    localparam int CNT_W  = ppao_pkg::CNT_W;
    localparam int DCNT_W = ppao_pkg::DCNT_W;

    logic              busy_reg,  busy_next;
    logic [DCNT_W-1:0] cnt_reg,   cnt_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [SC_W-1:0]   quo_reg,   quo_next;
    logic [CNT_W-1:0]  dsr_reg,   dsr_next;
    logic              neg_reg,   neg_next;
    logic [CNT_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SC_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(SC_W);
            rem_next  = '0;
            quo_next  = dividend[SC_W-1] ? SC_W'(-dividend) : SC_W'(dividend);
            dsr_next  = divisor;
            neg_next  = dividend[SC_W-1];
        end else if (busy_reg) begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
            quo_next  = {quo_reg[SC_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the polyphonic phase accumulator oscillator.
module tb;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES  = 200;   // longer than the worst tick latency, with margin
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

    typedef enum logic { ROW_WORD, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        req;
        logic [6:0]  slot;
        logic [31:0] step;
        logic [7:0]  voices;
        logic        cfg_sel;
        logic [3:0]  cfg_val;
        bit          has_exp;
        logic [7:0]  exp_sample;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [6:0]  voice_slot;
    logic [31:0] step_size;
    logic [7:0]  active_voices;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_sample;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [3:0]  cfg_data;

    // predictor state
    logic [31:0] phase_acc [ppao_pkg::MAX_VOICES];
    logic [31:0] voice_step [ppao_pkg::MAX_VOICES];
    int          sine_lut [ppao_pkg::SINE_ENTRIES];
    logic [1:0]  shape_reg;
    logic [3:0]  volume_reg;
    int          loaded_prefix;          // slots 0..loaded_prefix-1 all hold a step
    bit          slot_loaded [ppao_pkg::MAX_VOICES];

    logic [7:0]  sample_q [$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    bit          idle_on;
    bit          hold_req;
    bit          hold_done   = 1'b0;
    int          hold_cnt    = 0;
    int          stall_burst = 0;

    polyphonic_phase_accumulator_oscillator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .voice_slot    (voice_slot),
        .step_size     (step_size),
        .active_voices (active_voices),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_sample    (out_sample),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Quarter-wave sine in Q30: Taylor series to eight terms after scaling by pi/2.
    function automatic longint unsigned sin_q30(input longint unsigned frac);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned acc;
        if (frac >= 64'h4000_0000)
        begin
            return 64'h4000_0000;
        end
        x   = (frac * 64'd1686629713) >> 30;
        x2  = (x * x) >> 30;
        t   = x;
        acc = x;
        for (int k = 1; k <= 7; k++)
        begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - t;
            end
            else
            begin
                acc = acc + t;
            end
        end
        return acc;
    endfunction

    // Next mixed sample for a tick; advances the predictor's phases.
    function automatic logic [7:0] mix_sample(input int unsigned n_req);
        int unsigned n;
        int          vol;
        longint      total;
        longint      scaled;
        longint      res;
        logic [31:0] p;
        logic [31:0] mirror;
        logic [63:0] prod;
        n     = (n_req > ppao_pkg::MAX_VOICES) ? ppao_pkg::MAX_VOICES : n_req;
        vol   = (volume_reg > ppao_pkg::VOLUME_FULL) ? 8 : int'(volume_reg);
        total = 0;
        for (int v = 0; v < n; v++)
        begin
            p            = phase_acc[v] + voice_step[v];
            phase_acc[v] = p;
            mirror       = 32'd0 - p;
            prod         = 64'(p) * 64'(ppao_pkg::SINE_ENTRIES - 1);
            case (shape_reg)
                ppao_pkg::SHAPE_SAW:
                    total += longint'(p[31:24]) - 128;
                ppao_pkg::SHAPE_SQUARE:
                    total += (p < ppao_pkg::PHASE_HALF) ? 63 : -64;
                ppao_pkg::SHAPE_TRI:
                    total += (p < ppao_pkg::PHASE_HALF) ? longint'(p[31:24])
                                                        : longint'(mirror[31:24]);
                default:
                    total += sine_lut[prod[63:32]];
            endcase
        end
        // saw: floor shift; others: multiply then truncate toward zero
        if (shape_reg == ppao_pkg::SHAPE_SAW)
        begin
            scaled = total >>> (8 - vol);
        end
        else
        begin
            scaled = (total * vol) / 8;
        end
        res = (shape_reg == ppao_pkg::SHAPE_SQUARE) ? 64 : 128;
        if (n != 0)
        begin
            res += scaled / longint'(n);
        end
        if (res < 0)
        begin
            res = 0;
        end
        if (res > 255)
        begin
            res = 255;
        end
        return res[7:0];
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Hand one word to the block and record what it should produce.
    task automatic send_word(input logic req, input logic [6:0] slot,
                             input logic [31:0] step, input logic [7:0] voices,
                             input bit has_exp, input logic [7:0] exp_sample);
        logic [7:0] predicted;
        int         gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = int'($urandom_range(1, 11));
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= req;
        voice_slot    <= slot;
        step_size     <= step;
        active_voices <= voices;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // accepted at this edge
        if (req == ppao_pkg::REQ_LOAD)
        begin
            voice_step[slot]  = step;
            slot_loaded[slot] = 1'b1;
            while (loaded_prefix < ppao_pkg::MAX_VOICES && slot_loaded[loaded_prefix])
            begin
                loaded_prefix++;
            end
        end
        else
        begin
            predicted = mix_sample(voices);
            sample_q.push_back(has_exp ? exp_sample : predicted);
        end
    endtask

    // Drop valid and let the block drain before touching a register.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [3:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (sel == ppao_pkg::CFG_WAVE_SHAPE)
        begin
            shape_reg = val[1:0];
        end
        else
        begin
            volume_reg = val;
        end
    endtask

    task automatic random_word();
        logic [6:0] slot;
        logic [7:0] voices;
        if (loaded_prefix < ppao_pkg::MAX_VOICES && $urandom_range(0, 1) == 0)
        begin
            // grow the loaded prefix so ticks can reach more voices
            send_word(ppao_pkg::REQ_LOAD, 7'(loaded_prefix), pick_step(), 8'($urandom()),
                      1'b0, 8'd0);
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            slot = 7'($urandom_range(0, ppao_pkg::MAX_VOICES - 1));
            send_word(ppao_pkg::REQ_LOAD, slot, pick_step(), 8'($urandom()), 1'b0, 8'd0);
        end
        else
        begin
            if (loaded_prefix < ppao_pkg::MAX_VOICES)
            begin
                voices = 8'($urandom_range(0, loaded_prefix));
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       voices = 8'($urandom_range(ppao_pkg::MAX_VOICES + 1, 255));
                    1:       voices = 8'(ppao_pkg::MAX_VOICES);
                    2, 3:    voices = 8'($urandom_range(0, 8));
                    default: voices = 8'($urandom_range(0, ppao_pkg::MAX_VOICES));
                endcase
            end
            send_word(ppao_pkg::REQ_TICK, 7'($urandom()), $urandom(), voices, 1'b0, 8'd0);
        end
    endtask

    // Result checker: each sample against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (sample_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected sample %0d", out_sample);
                end
            end
            else
            begin
                if (out_sample !== sample_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("sample mismatch: expected %0d, got %0d",
                                 sample_q[0], out_sample);
                    end
                end
                void'(sample_q.pop_front());
            end
        end
    end

    // Receiver back-pressure: random bursts, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done  <= 1'b1;
            hold_cnt   <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= (hold_cnt > 1);
        end
        else if (stall_burst > 0)
        begin
            stall_burst <= stall_burst - 1;
            out_stall   <= (stall_burst > 1);
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_burst <= int'($urandom_range(1, 11));
            out_stall   <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Watchdog: too long with nothing moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        stim_row_t   rows [$];
        logic [63:0] t;
        logic [63:0] u;
        logic [1:0]  q;
        int          mag;
        logic [1:0]  ph_shape;
        logic [3:0]  ph_vol;

        in_valid      = 1'b0;
        req_type      = ppao_pkg::REQ_LOAD;
        voice_slot    = '0;
        step_size     = '0;
        active_voices = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = ppao_pkg::CFG_WAVE_SHAPE;
        cfg_data      = '0;
        rst_n         = 1'b0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        shape_reg     = ppao_pkg::SHAPE_SAW;
        volume_reg    = ppao_pkg::VOLUME_RESET;
        loaded_prefix = 0;
        for (int v = 0; v < ppao_pkg::MAX_VOICES; v++)
        begin
            phase_acc[v]   = '0;
            voice_step[v]  = '0;
            slot_loaded[v] = 1'b0;
        end
        // truncated 127*sin table, quarter-turn reduced
        for (int i = 0; i < ppao_pkg::SINE_ENTRIES; i++)
        begin
            t = (64'(i) << 32) / 64'(ppao_pkg::SINE_ENTRIES);
            q = t[31:30];
            u = t & 64'h3FFF_FFFF;
            if (q[0])
            begin
                u = 64'h4000_0000 - u;
            end
            mag = int'((64'd127 * sin_q30(u)) >> 30);
            sine_lut[i] = q[1] ? -mag : mag;
        end

        // Directed rows: reset values, idle offsets, triangle saturation, every shape,
        // volume above full scale, zero volume, slot extremes, step extremes.
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd0, 1'b0, 4'd0,
                         1'b1, 8'd128});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_WAVE_SHAPE, 4'(ppao_pkg::SHAPE_SQUARE), 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd0, 1'b0, 4'd0,
                         1'b1, 8'd64});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_LOAD, 7'd0, 32'h7FFF_FFFF, 8'd0, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_LOAD, 7'd1, 32'h7FFF_FFFF, 8'd0, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_LOAD, 7'd127, 32'h8000_0000, 8'd0, 1'b0,
                         4'd0, 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_LOAD, 7'd2, 32'hFFFF_FFFF, 8'd0, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_WAVE_SHAPE, 4'(ppao_pkg::SHAPE_TRI), 1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_VOLUME, ppao_pkg::VOLUME_FULL, 1'b0, 8'd0});
        // both voices land on 0x7FFFFFFF: 128 each, 256 after offset, clamps to 255
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd2, 1'b0, 4'd0,
                         1'b1, 8'd255});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_VOLUME, 4'd15, 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd3, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_WAVE_SHAPE, 4'(ppao_pkg::SHAPE_SINE), 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd3, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_WAVE_SHAPE, 4'(ppao_pkg::SHAPE_SAW), 1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_VOLUME, 4'd0, 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd3, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_WAVE_SHAPE, 4'(ppao_pkg::SHAPE_SQUARE), 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd1, 1'b0, 4'd0,
                         1'b0, 8'd0});
        rows.push_back('{ROW_CFG, ppao_pkg::REQ_LOAD, 7'd0, 32'd0, 8'd0,
                         ppao_pkg::CFG_VOLUME, ppao_pkg::VOLUME_FULL, 1'b0, 8'd0});
        rows.push_back('{ROW_WORD, ppao_pkg::REQ_TICK, 7'd0, 32'd0, 8'd3, 1'b0, 4'd0,
                         1'b0, 8'd0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                write_reg(rows[i].cfg_sel, rows[i].cfg_val);
            end
            else
            begin
                send_word(rows[i].req, rows[i].slot, rows[i].step, rows[i].voices,
                          rows[i].has_exp, rows[i].exp_sample);
            end
        end

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin ph_shape = ppao_pkg::SHAPE_SAW;    ph_vol = 4'd6;  end
                1: begin ph_shape = ppao_pkg::SHAPE_SQUARE; ph_vol = 4'd15; end
                2: begin ph_shape = ppao_pkg::SHAPE_TRI;    ph_vol = 4'd8;  end
                3: begin ph_shape = ppao_pkg::SHAPE_SINE;   ph_vol = 4'd0;  end
                4: begin ph_shape = ppao_pkg::SHAPE_SAW;    ph_vol = 4'd8;  end
                5: begin ph_shape = ppao_pkg::SHAPE_SINE;   ph_vol = 4'd9;  end
                6: begin ph_shape = ppao_pkg::SHAPE_TRI;    ph_vol = 4'd15; end
                7: begin ph_shape = ppao_pkg::SHAPE_SQUARE; ph_vol = 4'd1;  end
                8: begin ph_shape = ppao_pkg::SHAPE_SAW;    ph_vol = 4'd0;  end
                default:
                begin
                    ph_shape = 2'($urandom_range(0, 3));
                    ph_vol   = 4'($urandom_range(0, 15));
                    idle_on  = 1'b0;  // last stretch runs flat out
                end
            endcase
            write_reg(ppao_pkg::CFG_WAVE_SHAPE, 4'(ph_shape));
            write_reg(ppao_pkg::CFG_VOLUME, ph_vol);
            for (int k = 0; k < 43; k++)
            begin
                // long receiver hold-off while words keep coming
                if (ph == 2 && k == 10)
                begin
                    hold_req = 1'b1;
                end
                // sender waits until every sample is back
                if (ph == 5 && k == 20)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (sample_q.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
                random_word();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
